### rtl/bcc_pkg.sv
`default_nettype none

package bcc_pkg;

    // widths fixed by the transaction fields
    localparam int NOW_W      = 32;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    // default timer width
    localparam int TIME_WIDTH_DEF = 32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TIME   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_TIME = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_CLICK    = 2'd2;

    // reset values of the configuration registers, in ms
    localparam logic [CFG_DATA_W-1:0] DEBOUNCE_TIME_RST   = 16'd20;
    localparam logic [CFG_DATA_W-1:0] LONG_PRESS_TIME_RST = 16'd2000;
    localparam logic [CFG_DATA_W-1:0] DOUBLE_CLICK_RST    = 16'd400;

    // click counter saturation and the single and double click values
    localparam logic [1:0] CLICK_MAX    = 2'd3;
    localparam logic [1:0] CLICK_DOUBLE = 2'd2;
    localparam logic [1:0] CLICK_SINGLE = 2'd1;

    typedef struct packed {
        logic              button_level;
        logic [NOW_W-1:0]  now_ms;
    } t_bcc_in;

    typedef struct packed {
        logic pause_toggled;
        logic mode_toggled;
        logic restart_request;
        logic paused_now;
        logic measure_mode_now;
    } t_bcc_out;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] debounce_time;
        logic [CFG_DATA_W-1:0] long_press_time;
        logic [CFG_DATA_W-1:0] double_click_window;
    } t_bcc_cfg;

endpackage

`default_nettype wire

### rtl/bcc_cfg_regs.sv
`default_nettype none

module bcc_cfg_regs (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [bcc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [bcc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output bcc_pkg::t_bcc_cfg                     o_cfg
);
    import bcc_pkg::*;

    t_bcc_cfg r_cfg;

    // register file, writes beyond the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_time       <= DEBOUNCE_TIME_RST;
            r_cfg.long_press_time     <= LONG_PRESS_TIME_RST;
            r_cfg.double_click_window <= DOUBLE_CLICK_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_DEBOUNCE_TIME:   r_cfg.debounce_time       <= i_cfg_data;
                REG_LONG_PRESS_TIME: r_cfg.long_press_time     <= i_cfg_data;
                REG_DOUBLE_CLICK:    r_cfg.double_click_window <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

### rtl/bcc_classify.sv
`default_nettype none

module bcc_classify #(
    parameter int TIME_WIDTH = bcc_pkg::TIME_WIDTH_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_step,
    input  bcc_pkg::t_bcc_in   i_item,
    input  bcc_pkg::t_bcc_cfg  i_cfg,
    output bcc_pkg::t_bcc_out  o_result
);
    import bcc_pkg::*;

    // tracking state
    logic                  r_prev_level;
    logic [TIME_WIDTH-1:0] r_deb_stamp;
    logic [TIME_WIDTH-1:0] r_press_stamp;
    logic                  r_is_pressed;
    logic                  r_long_fired;
    logic [TIME_WIDTH-1:0] r_click_stamp;
    logic [1:0]            r_click_count;
    logic                  r_pause_flag;
    logic                  r_mode_flag;

    logic [TIME_WIDTH-1:0] n_deb_stamp;
    logic [TIME_WIDTH-1:0] n_press_stamp;
    logic                  n_is_pressed;
    logic                  n_long_fired;
    logic [TIME_WIDTH-1:0] n_click_stamp;
    logic [1:0]            n_click_count;
    logic                  n_pause_flag;
    logic                  n_mode_flag;

    logic [TIME_WIDTH-1:0] now_t;
    logic [TIME_WIDTH-1:0] deb_time;
    logic [TIME_WIDTH-1:0] long_time;
    logic [TIME_WIDTH-1:0] dbl_window;
    logic [TIME_WIDTH-1:0] el_deb;
    logic [TIME_WIDTH-1:0] el_click;
    logic [TIME_WIDTH-1:0] el_press;
    logic                  stable;
    logic                  pause_t;
    logic                  mode_t;
    logic                  restart;

    // timestamp and thresholds at timer width, differences wrap
    assign now_t      = TIME_WIDTH'(i_item.now_ms);
    assign deb_time   = TIME_WIDTH'(i_cfg.debounce_time);
    assign long_time  = TIME_WIDTH'(i_cfg.long_press_time);
    assign dbl_window = TIME_WIDTH'(i_cfg.double_click_window);

    assign n_deb_stamp = (i_item.button_level != r_prev_level) ? now_t : r_deb_stamp;
    assign el_deb      = now_t - n_deb_stamp;
    assign el_click    = now_t - r_click_stamp;
    assign stable      = el_deb > deb_time;

    // press, release and long press classification
    always_comb begin
        n_press_stamp = r_press_stamp;
        n_is_pressed  = r_is_pressed;
        n_long_fired  = r_long_fired;
        n_click_stamp = r_click_stamp;
        n_click_count = r_click_count;
        n_pause_flag  = r_pause_flag;
        n_mode_flag   = r_mode_flag;
        el_press      = '0;
        pause_t       = 1'b0;
        mode_t        = 1'b0;
        restart       = 1'b0;
        if (stable) begin
            if (!i_item.button_level && !r_is_pressed) begin
                n_is_pressed  = 1'b1;
                n_press_stamp = now_t;
                n_long_fired  = 1'b0;
            end else if (i_item.button_level && r_is_pressed) begin
                n_is_pressed = 1'b0;
                if (el_click < dbl_window) begin
                    if (r_click_count != CLICK_MAX) begin
                        n_click_count = r_click_count + 2'd1;
                    end
                end else begin
                    n_click_count = CLICK_SINGLE;
                end
                n_click_stamp = now_t;
                if (n_click_count == CLICK_DOUBLE) begin
                    n_mode_flag = !r_mode_flag;
                    mode_t      = 1'b1;
                end else if (!r_long_fired) begin
                    n_pause_flag = !r_pause_flag;
                    pause_t      = 1'b1;
                end
            end
            // press duration measured from the possibly fresh press stamp
            el_press = now_t - n_press_stamp;
            if (n_is_pressed && !n_long_fired && (el_press >= long_time)) begin
                n_long_fired = 1'b1;
                restart      = 1'b1;
            end
        end
    end

    // state update once per transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_level  <= 1'b1;
            r_deb_stamp   <= '0;
            r_press_stamp <= '0;
            r_is_pressed  <= 1'b0;
            r_long_fired  <= 1'b0;
            r_click_stamp <= '0;
            r_click_count <= '0;
            r_pause_flag  <= 1'b0;
            r_mode_flag   <= 1'b0;
        end else if (i_step) begin
            r_prev_level  <= i_item.button_level;
            r_deb_stamp   <= n_deb_stamp;
            r_press_stamp <= n_press_stamp;
            r_is_pressed  <= n_is_pressed;
            r_long_fired  <= n_long_fired;
            r_click_stamp <= n_click_stamp;
            r_click_count <= n_click_count;
            r_pause_flag  <= n_pause_flag;
            r_mode_flag   <= n_mode_flag;
        end
    end

    assign o_result.pause_toggled    = pause_t;
    assign o_result.mode_toggled     = mode_t;
    assign o_result.restart_request  = restart;
    assign o_result.paused_now       = n_pause_flag;
    assign o_result.measure_mode_now = n_mode_flag;

`ifndef ASSERT_OFF
    // a release toggles either mode or pause, never both
    a_one_toggle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step |-> !(pause_t && mode_t))
        else $error("pause and mode toggled together");

    // a mode toggle comes only from the second click
    a_mode_double: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && mode_t) |=> (r_click_count == CLICK_DOUBLE) && !r_is_pressed)
        else $error("mode toggled without a double click");

    // a restart request leaves a held press marked as long
    a_restart_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && restart) |=> r_long_fired && r_is_pressed)
        else $error("restart request without long press marking");

    // a pause toggle really flips the flag
    a_pause_flip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && pause_t) |=> r_pause_flag != $past(r_pause_flag))
        else $error("pause toggle did not flip the pause flag");
`endif

endmodule

`default_nettype wire

### rtl/button_click_classifier_unit.sv
// button click classifier
//
// input channel: one transaction per button poll, carrying the raw active-low
// pin level and a free-running millisecond timestamp (i_in_valid/o_in_stall).
// output channel: one transaction per poll with the pause and mode toggle
// strobes, the one-shot restart request and the current pause and mode flags
// (o_out_valid/i_out_stall). configuration: plain write port, index 0
// debounce time, 1 long press time, 2 double click window; any other index is
// ignored. the user writes it only when idle; the block does not enforce this.
//
// a poll is taken into the input register when accepted, and its result is
// registered into the result register when it advances, raising o_out_valid.
// throughput: one poll per cycle except while the receiver stalls.
// reset: timers and flags clear, the level reads as released, and the
// configuration returns to 20, 2000 and 400 ms; both pipeline stages empty.
// receiver stall: the result register holds, the input register holds behind
// it, and o_in_stall rises once both stages are full.

`default_nettype none

module button_click_classifier_unit #(
    parameter int TIME_WIDTH = bcc_pkg::TIME_WIDTH_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output      logic                            o_in_stall,
    input  bcc_pkg::t_bcc_in                     i_in_data,
    output      logic                            o_out_valid,
    input  wire logic                            i_out_stall,
    output bcc_pkg::t_bcc_out                    o_out_data,
    input  wire logic                            i_cfg_we,
    input  wire logic [bcc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [bcc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import bcc_pkg::*;

    t_bcc_cfg cfg;
    t_bcc_in  r_in;
    logic     r_in_valid;
    t_bcc_out r_out;
    logic     r_out_valid;
    t_bcc_out result;
    logic     advance;
    logic     in_load;

    // pipeline control
    assign advance    = !r_out_valid || !i_out_stall;
    assign in_load    = !r_in_valid || advance;
    assign o_in_stall = !in_load;

    bcc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    bcc_classify #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_classify (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (r_in_valid && advance),
        .i_item   (r_in),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_load) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef ASSERT_OFF
    // a held input transaction is not lost while the output drains
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> r_in_valid && $stable(r_in))
        else $error("input stage dropped a waiting transaction");

    // stall upstream only when both stages are occupied
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid && r_out_valid)
        else $error("input stalled with a free stage");

    // an item in the input stage reaches the result register when it advances
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && advance) |=> r_out_valid)
        else $error("advanced transaction missing from result register");
`endif

endmodule

`default_nettype wire
